>>> hw/rtl/mlr_pkg.sv
`default_nettype none

package mlr_pkg;

  // Coordinate width of every endpoint and pixel.
  localparam int COORD_BITS = 12;
  // A length along one axis needs one more bit than a coordinate.
  localparam int DELTA_BITS = COORD_BITS + 1;
  // The decision variable stays well within four times the longest length.
  localparam int DEC_BITS   = COORD_BITS + 4;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] CASE_SHALLOW_POS = 2'd0;
  localparam logic [1:0] CASE_STEEP_POS   = 2'd1;
  localparam logic [1:0] CASE_SHALLOW_NEG = 2'd2;
  localparam logic [1:0] CASE_STEEP_NEG   = 2'd3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [DELTA_BITS-1:0]        delta_t;
  typedef logic signed [DEC_BITS-1:0]   dec_t;

  // Everything a load item sets up for the line that follows.
  typedef struct packed {
    coord_t     start_x;
    coord_t     start_y;
    coord_t     target;
    delta_t     major;
    delta_t     minor;
    dec_t       decision;
    logic [1:0] case_sel;
    logic       active;
  } line_setup_t;

endpackage

`default_nettype wire

>>> hw/rtl/mlr_if.sv
`default_nettype none

interface mlr_in_if import mlr_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   opcode;
  coord_t x_start;
  coord_t y_start;
  coord_t x_end;
  coord_t y_end;

  modport source (output valid, opcode, x_start, y_start, x_end, y_end, input ready);
  modport sink   (input valid, opcode, x_start, y_start, x_end, y_end, output ready);
endinterface

interface mlr_out_if import mlr_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t pixel_x;
  coord_t pixel_y;
  logic   last_pixel;

  modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mlr_setup.sv
`default_nettype none

// Orders the endpoints so that x runs upward, picks the octant pair and
// forms the initial decision value.
module mlr_setup import mlr_pkg::*; (
  input  coord_t      x_start,
  input  coord_t      y_start,
  input  coord_t      x_end,
  input  coord_t      y_end,
  output line_setup_t setup
);

  logic                         swap;
  coord_t                       xs, ys, xe, ye;
  delta_t                       dx;
  logic signed [DELTA_BITS-1:0] dy;
  delta_t                       ady;
  logic                         shallow;
  delta_t                       major, minor;

  assign swap = x_start > x_end;
  assign xs   = swap ? x_end   : x_start;
  assign ys   = swap ? y_end   : y_start;
  assign xe   = swap ? x_start : x_end;
  assign ye   = swap ? y_start : y_end;

  assign dx  = delta_t'(DELTA_BITS'(xe) - DELTA_BITS'(xs));
  assign dy  = DELTA_BITS'(ye) - DELTA_BITS'(ys);
  assign ady = dy[DELTA_BITS-1] ? delta_t'(-dy) : delta_t'(dy);

  assign shallow = ady <= dx;
  assign major   = shallow ? dx  : ady;
  assign minor   = shallow ? ady : dx;

  always_comb begin
    setup.start_x  = xs;
    setup.start_y  = ys;
    setup.target   = shallow ? xe : ye;
    setup.major    = major;
    setup.minor    = minor;
    setup.decision = dec_t'({minor, 1'b0}) - dec_t'(major);
    if (shallow) begin
      setup.case_sel = dy[DELTA_BITS-1] ? CASE_SHALLOW_NEG : CASE_SHALLOW_POS;
    end else begin
      setup.case_sel = dy[DELTA_BITS-1] ? CASE_STEEP_NEG : CASE_STEEP_POS;
    end
    setup.active   = major != '0;
  end

endmodule

`default_nettype wire

>>> hw/rtl/midpoint_line_rasterizer.sv
`default_nettype none

// Midpoint line engine. A load item (opcode 0) carries two signed endpoints
// and produces the line's start pixel at once; every tick item (opcode 1)
// then produces the next pixel, and the end point is flagged with
// last_pixel. A tick while no line is being drawn produces nothing, and a
// load during a line abandons it. Endpoints are reordered so that x always
// increases, so a line is drawn from its left end. The engine takes one item
// per clock cycle while its input is not stalled, and the result is registered
// in the cycle after the item is accepted: each tick is a single add on the
// decision value and a step of one along the major axis and, when due, the
// minor axis, all done between the accepted item and the result register. The
// input stalls only while a result sits in that register and the downstream side does not take it.
module midpoint_line_rasterizer import mlr_pkg::*; (
  input  wire           clk,
  input  wire           rst_n,
  mlr_in_if.sink        in_chan,
  mlr_out_if.source     out_chan
);

  line_setup_t setup;

  mlr_setup u_setup (
    .x_start (in_chan.x_start),
    .y_start (in_chan.y_start),
    .x_end   (in_chan.x_end),
    .y_end   (in_chan.y_end),
    .setup   (setup)
  );

  // Line state.
  coord_t     cursor_x_r, cursor_x_nxt;
  coord_t     cursor_y_r, cursor_y_nxt;
  coord_t     target_r, target_nxt;
  delta_t     major_r, major_nxt;
  delta_t     minor_r, minor_nxt;
  dec_t       decision_r, decision_nxt;
  logic [1:0] case_sel_r, case_sel_nxt;
  logic       line_active_r, line_active_nxt;

  // Result register.
  logic       out_valid_r, out_valid_nxt;
  coord_t     out_x_r, out_x_nxt;
  coord_t     out_y_r, out_y_nxt;
  logic       out_last_r, out_last_nxt;

  logic       in_accept;
  logic       is_load;
  logic       minor_step;
  coord_t     step_x, step_y;
  logic       step_last;

  // A new item may enter whenever the result register is empty or is being
  // emptied in this cycle.
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_accept     = in_chan.valid && in_chan.ready;
  assign is_load       = in_chan.opcode == OP_LOAD;

  // One step along the major axis; the minor axis follows when the decision
  // value is not negative.
  assign minor_step = !decision_r[DEC_BITS-1];

  always_comb begin
    step_x = cursor_x_r;
    step_y = cursor_y_r;
    unique case (case_sel_r)
      CASE_SHALLOW_POS: begin
        step_x = cursor_x_r + coord_t'(1);
        if (minor_step) step_y = cursor_y_r + coord_t'(1);
      end
      CASE_SHALLOW_NEG: begin
        step_x = cursor_x_r + coord_t'(1);
        if (minor_step) step_y = cursor_y_r - coord_t'(1);
      end
      CASE_STEEP_POS: begin
        step_y = cursor_y_r + coord_t'(1);
        if (minor_step) step_x = cursor_x_r + coord_t'(1);
      end
      CASE_STEEP_NEG: begin
        step_y = cursor_y_r - coord_t'(1);
        if (minor_step) step_x = cursor_x_r + coord_t'(1);
      end
      default: begin
        step_x = cursor_x_r;
        step_y = cursor_y_r;
      end
    endcase
    // Even codes are the shallow cases, where x is the major axis.
    step_last = case_sel_r[0] ? (step_y == target_r) : (step_x == target_r);
  end

  always_comb begin
    cursor_x_nxt    = cursor_x_r;
    cursor_y_nxt    = cursor_y_r;
    target_nxt      = target_r;
    major_nxt       = major_r;
    minor_nxt       = minor_r;
    decision_nxt    = decision_r;
    case_sel_nxt    = case_sel_r;
    line_active_nxt = line_active_r;
    out_valid_nxt   = out_valid_r && !out_chan.ready;
    out_x_nxt       = out_x_r;
    out_y_nxt       = out_y_r;
    out_last_nxt    = out_last_r;

    if (in_accept) begin
      if (is_load) begin
        cursor_x_nxt    = setup.start_x;
        cursor_y_nxt    = setup.start_y;
        target_nxt      = setup.target;
        major_nxt       = setup.major;
        minor_nxt       = setup.minor;
        decision_nxt    = setup.decision;
        case_sel_nxt    = setup.case_sel;
        line_active_nxt = setup.active;
        out_valid_nxt   = 1'b1;
        out_x_nxt       = setup.start_x;
        out_y_nxt       = setup.start_y;
        // A line of a single point ends where it starts.
        out_last_nxt    = !setup.active;
      end else if (line_active_r) begin
        cursor_x_nxt    = step_x;
        cursor_y_nxt    = step_y;
        if (minor_step) begin
          decision_nxt = decision_r + dec_t'({minor_r, 1'b0}) - dec_t'({major_r, 1'b0});
        end else begin
          decision_nxt = decision_r + dec_t'({minor_r, 1'b0});
        end
        line_active_nxt = !step_last;
        out_valid_nxt   = 1'b1;
        out_x_nxt       = step_x;
        out_y_nxt       = step_y;
        out_last_nxt    = step_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r    <= '0;
      cursor_y_r    <= '0;
      target_r      <= '0;
      major_r       <= '0;
      minor_r       <= '0;
      decision_r    <= '0;
      case_sel_r    <= CASE_SHALLOW_POS;
      line_active_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      cursor_x_r    <= cursor_x_nxt;
      cursor_y_r    <= cursor_y_nxt;
      target_r      <= target_nxt;
      major_r       <= major_nxt;
      minor_r       <= minor_nxt;
      decision_r    <= decision_nxt;
      case_sel_r    <= case_sel_nxt;
      line_active_r <= line_active_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.pixel_x    = out_x_r;
  assign out_chan.pixel_y    = out_y_r;
  assign out_chan.last_pixel = out_last_r;

  // A tick taken while idle leaves the result register empty.
  a_idle_tick_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !is_load && !line_active_r) |=> !out_valid_r)
    else $error("idle tick produced a result");

  // After a load the last flag agrees with whether a line remains to draw.
  a_load_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && is_load) |=> (out_valid_r && (out_last_r == !line_active_r)))
    else $error("load result and line state disagree");

  // A drawing tick ends the line exactly when it flags the last pixel.
  a_tick_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !is_load && line_active_r) |=>
      (out_valid_r && (out_last_r == !line_active_r)))
    else $error("tick result and line state disagree");

  // The emitted pixel is the cursor the line state now holds.
  a_cursor_match: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (is_load || line_active_r)) |=>
      ((out_x_r == cursor_x_r) && (out_y_r == cursor_y_r)))
    else $error("emitted pixel differs from cursor");

endmodule

`default_nettype wire

>>> bench/pixel_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the line engine. It predicts the pixel, if any, that
// each accepted item produces and compares each accepted result with the oldest
// pixel still awaited.
module pixel_checker import mlr_pkg::*; (
  input  wire clk,
  input  wire rst_n,
  mlr_in_if   in_mon,
  mlr_out_if  out_mon,
  output int  mismatches,
  output int  outstanding
);

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  // Shadow copy of the engine's drawing state.
  coord_t     pen_x;
  coord_t     pen_y;
  coord_t     stop_major;
  delta_t     run_major;
  delta_t     run_minor;
  dec_t       err_term;
  logic [1:0] octant;
  logic       drawing;

  pixel_t pending_pixels[$];
  int     faults = 0;

  task automatic log_fault(input string msg);
    faults++;
    if (faults <= 10) begin
      $display("%0t ns: pixel mismatch: %s", $time, msg);
    end
  endtask

  // Works out the pixel, if any, that one accepted item produces.
  function automatic void trace_step(input logic op, input coord_t xs, input coord_t ys,
                                     input coord_t xe, input coord_t ye,
                                     output bit emits, output pixel_t pix);
    int  ax, ay, bx, by, swap, span_x, span_y, abs_y;
    bit  step_minor;
    bit  at_end;
    emits = 1'b0;
    pix = '0;
    if (op == OP_LOAD) begin
      ax = xs;
      ay = ys;
      bx = xe;
      by = ye;
      if (ax > bx) begin
        swap = ax; ax = bx; bx = swap;
        swap = ay; ay = by; by = swap;
      end
      span_x = bx - ax;
      span_y = by - ay;
      abs_y = (span_y < 0) ? -span_y : span_y;
      if (abs_y <= span_x) begin
        octant = (span_y < 0) ? CASE_SHALLOW_NEG : CASE_SHALLOW_POS;
        run_major = delta_t'(span_x);
        run_minor = delta_t'(abs_y);
        stop_major = coord_t'(bx);
        err_term = dec_t'(2 * abs_y - span_x);
      end else begin
        octant = (span_y > 0) ? CASE_STEEP_POS : CASE_STEEP_NEG;
        run_major = delta_t'(abs_y);
        run_minor = delta_t'(span_x);
        stop_major = coord_t'(by);
        err_term = dec_t'(2 * span_x - abs_y);
      end
      pen_x = coord_t'(ax);
      pen_y = coord_t'(ay);
      drawing = (run_major != '0);
      emits = 1'b1;
      pix = '{pen_x, pen_y, !drawing};
    end else if (drawing) begin
      step_minor = (err_term >= 0);
      if (step_minor) begin
        err_term = dec_t'(int'(err_term) + 2 * (int'(run_minor) - int'(run_major)));
      end else begin
        err_term = dec_t'(int'(err_term) + 2 * int'(run_minor));
      end
      if (octant == CASE_SHALLOW_POS || octant == CASE_SHALLOW_NEG) begin
        pen_x = coord_t'(pen_x + 1);
        if (step_minor) begin
          pen_y = (octant == CASE_SHALLOW_NEG) ? coord_t'(pen_y - 1) : coord_t'(pen_y + 1);
        end
        at_end = (pen_x == stop_major);
      end else begin
        pen_y = (octant == CASE_STEEP_POS) ? coord_t'(pen_y + 1) : coord_t'(pen_y - 1);
        if (step_minor) begin
          pen_x = coord_t'(pen_x + 1);
        end
        at_end = (pen_y == stop_major);
      end
      if (at_end) begin
        drawing = 1'b0;
      end
      emits = 1'b1;
      pix = '{pen_x, pen_y, at_end};
    end
  endfunction

  always @(posedge clk) begin
    pixel_t want;
    pixel_t got;
    pixel_t made;
    bit     emits;
    if (!rst_n) begin
      pen_x = '0;
      pen_y = '0;
      stop_major = '0;
      run_major = '0;
      run_minor = '0;
      err_term = '0;
      octant = CASE_SHALLOW_POS;
      drawing = 1'b0;
      pending_pixels.delete();
    end else begin
      // A result taken at this edge always stems from an earlier item, so it
      // is matched before this edge's item is predicted.
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.pixel_x, out_mon.pixel_y, out_mon.last_pixel};
        if (pending_pixels.size() == 0) begin
          log_fault($sformatf("unexpected pixel (%0d,%0d) last=%0b",
                              got.x, got.y, got.last));
        end else begin
          want = pending_pixels.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.last !== want.last) begin
            log_fault($sformatf("expected (%0d,%0d) last=%0b, got (%0d,%0d) last=%0b",
                                want.x, want.y, want.last, got.x, got.y, got.last));
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        trace_step(in_mon.opcode, in_mon.x_start, in_mon.y_start, in_mon.x_end,
                   in_mon.y_end, emits, made);
        if (emits) begin
          pending_pixels.push_back(made);
        end
      end
    end
    mismatches <= faults;
    outstanding <= pending_pixels.size();
  end

endmodule

>>> bench/tb_midpoint_line_rasterizer.sv
`timescale 1ns / 100ps

// Top of the line engine's bench. This module only makes stimulus and gives
// the verdict; all prediction and comparison happens in the pixel checker
// that sits beside the block and watches both channels.
module tb_midpoint_line_rasterizer;
  import mlr_pkg::*;

  localparam int COORD_MIN = -(1 << (COORD_BITS - 1));
  localparam int COORD_MAX = (1 << (COORD_BITS - 1)) - 1;
  localparam int RANDOM_ITEMS = 1250;
  // Items sent without any idling at the very end of the run.
  localparam int CALM_TAIL = 150;
  // Ticks given to the one full-width line before it is abandoned.
  localparam int LONG_TICKS = 96;

  logic clk = 1'b0;
  logic rst_n;

  mlr_in_if  in_chan ();
  mlr_out_if out_chan ();

  int mismatches;
  int outstanding;

  // Items accepted so far.
  int sent = 0;
  // idle_on switches idling on and off for whole stretches; quiet switches
  // it off for good near the end.
  bit idle_on = 1'b1;
  bit quiet = 1'b0;
  int stall_left = 0;

  midpoint_line_rasterizer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  pixel_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // The downstream side. Stalls come in bursts and are decided at the falling
  // edge, so that the engine sees a steady ready at the rising edge.
  always @(negedge clk) begin
    if (!rst_n || quiet || !idle_on) begin
      out_chan.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_chan.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  function automatic coord_t any_coord();
    return coord_t'($urandom_range(0, (1 << COORD_BITS) - 1));
  endfunction

  // Presents one item at a falling edge, possibly after a short idle burst,
  // and holds it until the engine accepts it at a rising edge. Valid is only
  // assigned once per falling edge, so back-to-back items never see it
  // lowered and raised in the same step.
  task automatic push_item(input logic op, input coord_t xs, input coord_t ys,
                           input coord_t xe, input coord_t ye);
    int gap;
    gap = 0;
    if (!quiet && idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
    end
    if (gap > 0) begin
      @(negedge clk);
      in_chan.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_chan.valid   <= 1'b1;
    in_chan.opcode  <= op;
    in_chan.x_start <= xs;
    in_chan.y_start <= ys;
    in_chan.x_end   <= xe;
    in_chan.y_end   <= ye;
    do @(posedge clk); while (!in_chan.ready);
    sent++;
  endtask

  // A tick ignores the endpoint fields, so they are filled with noise.
  task automatic push_tick();
    push_item(OP_TICK, any_coord(), any_coord(), any_coord(), any_coord());
  endtask

  task automatic draw_line(input coord_t xs, input coord_t ys, input coord_t xe,
                           input coord_t ye, input int ticks);
    push_item(OP_LOAD, xs, ys, xe, ye);
    repeat (ticks) push_tick();
  endtask

  // Stimulus and verdict.
  initial begin
    int     reach, dx, dy, ex, ey, ax, ay, major, ticks, kind, shape;
    int     next_regime;
    bit     long_done, drained;
    coord_t sx, sy, tx, ty;

    in_chan.valid   = 1'b0;
    in_chan.opcode  = OP_TICK;
    in_chan.x_start = '0;
    in_chan.y_start = '0;
    in_chan.x_end   = '0;
    in_chan.y_end   = '0;
    rst_n = 1'b0;

    long_done = 1'b0;
    drained = 1'b0;
    next_regime = 150;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. A tick straight after reset finds the engine idle and
    // must produce nothing.
    push_tick();
    // Single points at both corners of the coordinate range: the start pixel
    // is also the last, and the tick after the first point produces nothing.
    draw_line(coord_t'(COORD_MIN), coord_t'(COORD_MIN), coord_t'(COORD_MIN),
              coord_t'(COORD_MIN), 1);
    draw_line(coord_t'(COORD_MAX), coord_t'(COORD_MAX), coord_t'(COORD_MAX),
              coord_t'(COORD_MAX), 0);
    // One short line per octant case. The shallow falling one is given from
    // right to left, so the engine must swap its endpoints first.
    draw_line(coord_t'(0), coord_t'(0), coord_t'(3), coord_t'(1), 3);
    draw_line(coord_t'(5), coord_t'(5), coord_t'(1), coord_t'(7), 4);
    draw_line(coord_t'(0), coord_t'(0), coord_t'(1), coord_t'(3), 3);
    draw_line(coord_t'(0), coord_t'(0), coord_t'(1), coord_t'(-3), 3);
    // A line across the whole range, abandoned after two ticks by a fresh
    // load, which itself is a short horizontal line.
    draw_line(coord_t'(COORD_MIN), coord_t'(COORD_MIN), coord_t'(COORD_MAX),
              coord_t'(COORD_MAX), 2);
    draw_line(coord_t'(-4), coord_t'(9), coord_t'(-1), coord_t'(9), 3);

    // Random part. Most of it is whole lines with random endpoints, drawn
    // to the end; some lines are abandoned early, some get surplus ticks
    // that find the engine idle, and a few items are pure noise.
    while (sent < RANDOM_ITEMS) begin
      if (sent >= next_regime) begin
        idle_on = ($urandom_range(0, 9) < 7);
        next_regime += 150;
      end
      quiet = (sent >= RANDOM_ITEMS - CALM_TAIL);

      // One line spanning the full range on its major axis, so that the
      // decision value reaches its widest swing within its first ticks; it
      // is abandoned after a stretch of ticks by the next load.
      if (!long_done && sent >= 400) begin
        if ($urandom_range(0, 1)) begin
          sx = coord_t'(COORD_MIN);
          tx = coord_t'(COORD_MAX);
          sy = any_coord();
          ty = any_coord();
        end else begin
          sy = coord_t'(COORD_MIN);
          ty = coord_t'(COORD_MAX);
          sx = any_coord();
          tx = any_coord();
        end
        if ($urandom_range(0, 1)) begin
          draw_line(tx, ty, sx, sy, LONG_TICKS);
        end else begin
          draw_line(sx, sy, tx, ty, LONG_TICKS);
        end
        long_done = 1'b1;
      end

      // Hold the input off once until every awaited pixel has come out.
      if (!drained && sent >= 700) begin
        @(negedge clk);
        in_chan.valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        drained = 1'b1;
      end

      kind = $urandom_range(0, 99);
      if (kind < 6) begin
        push_item(logic'($urandom_range(0, 1)), any_coord(), any_coord(), any_coord(),
                  any_coord());
      end else begin
        sx = any_coord();
        sy = any_coord();
        if (kind < 14) begin
          // Long line with free endpoints, usually abandoned part way.
          ex = any_coord();
          ey = any_coord();
          ticks = $urandom_range(0, 40);
        end else begin
          reach = $urandom_range(0, 12);
          dx = int'($urandom_range(0, 2 * reach)) - reach;
          dy = int'($urandom_range(0, 2 * reach)) - reach;
          shape = $urandom_range(0, 9);
          if (shape == 0) begin
            dy = 0;
          end else if (shape == 1) begin
            dx = 0;
          end else if (shape == 2) begin
            dy = $urandom_range(0, 1) ? dx : -dx;
          end
          // Mirror the offset where it would leave the coordinate range.
          ex = sx + dx;
          if (ex > COORD_MAX || ex < COORD_MIN) begin
            ex = sx - dx;
          end
          ey = sy + dy;
          if (ey > COORD_MAX || ey < COORD_MIN) begin
            ey = sy - dy;
          end
          ax = (ex > sx) ? ex - sx : sx - ex;
          ay = (ey > sy) ? ey - sy : sy - ey;
          major = (ax > ay) ? ax : ay;
          shape = $urandom_range(0, 9);
          if (shape == 0) begin
            ticks = $urandom_range(0, major);
          end else if (shape == 1) begin
            ticks = major + $urandom_range(1, 3);
          end else begin
            ticks = major;
          end
        end
        draw_line(sx, sy, coord_t'(ex), coord_t'(ey), ticks);
      end
    end

    // Drain: wait for every awaited pixel, and keep the input idle before the
    // verdict so that a stray result would still be caught.
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
